FILE: hw/rtl/rwp_pkg.sv
// ----------------------------------------------------------------------------
// rwp_pkg
// Shared types and constants for the RIFF/WAVE float stream parser: chunk
// tags, fmt chunk expectations, result kinds, error codes and result record.
// ----------------------------------------------------------------------------
package rwp_pkg;

	// Four-byte tags as assembled little-endian
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_LIST = 32'h5453_494C;
	localparam logic [31:0] TAG_ID3  = 32'h2033_6469;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_FACT = 32'h7463_6166;
	localparam logic [31:0] TAG_PEAK = 32'h4B41_4550;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	// fmt chunk expectations
	localparam logic [31:0] FMT_CHUNK_LEN   = 32'd16;
	localparam logic [15:0] FMT_IEEE_FLOAT  = 16'd3;
	localparam logic [15:0] FMT_MONO        = 16'd1;
	localparam logic [15:0] FMT_BLOCK_ALIGN = 16'd4;
	localparam logic [15:0] FMT_SAMPLE_BITS = 16'd32;

	// Byte counts of the framing
	localparam logic [31:0] WAVE_TAG_LEN  = 32'd4;
	localparam logic [31:0] CHUNK_HDR_LEN = 32'd8;

	typedef enum logic [1:0] {
		RK_SAMPLE = 2'd0,
		RK_DONE   = 2'd1,
		RK_ERROR  = 2'd2
	} res_kind_t;

	typedef enum logic [4:0] {
		ERR_NONE       = 5'd0,
		ERR_MAGIC      = 5'd1,
		ERR_NOT_WAVE   = 5'd2,
		ERR_OVERRUN    = 5'd3,
		ERR_DUP_FMT    = 5'd4,
		ERR_FMT_SIZE   = 5'd5,
		ERR_FORMAT     = 5'd6,
		ERR_CHANNELS   = 5'd7,
		ERR_RATE_ZERO  = 5'd8,
		ERR_BYTE_RATE  = 5'd9,
		ERR_ALIGN      = 5'd10,
		ERR_BITS       = 5'd11,
		ERR_DUP_DATA   = 5'd12,
		ERR_EMPTY_DATA = 5'd13,
		ERR_PARTIAL    = 5'd14,
		ERR_UNKNOWN_ID = 5'd15,
		ERR_NO_FMT     = 5'd16,
		ERR_NO_DATA    = 5'd17,
		ERR_TRUNCATED  = 5'd18
	} err_code_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] sample_bits;
		logic [31:0] rate_hz;
		logic [4:0]  error_code;
	} rwp_result_t;

endpackage

FILE: hw/rtl/rwp_in_if.sv
// ----------------------------------------------------------------------------
// rwp_in_if
// Byte request channel: one file byte plus an end-of-stream mark.
// ----------------------------------------------------------------------------
interface rwp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

FILE: hw/rtl/rwp_out_if.sv
// ----------------------------------------------------------------------------
// rwp_out_if
// Result request channel: sample word, completion with rate, or error.
// ----------------------------------------------------------------------------
interface rwp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] sample_bits;
	logic [31:0] rate_hz;
	logic [4:0]  error_code;

	modport source (output valid, output kind, output sample_bits, output rate_hz,
		output error_code, input ready);
	modport sink   (input valid, input kind, input sample_bits, input rate_hz,
		input error_code, output ready);
endinterface

FILE: hw/rtl/rwp_parse_core.sv
// ----------------------------------------------------------------------------
// rwp_parse_core
// Parse state and combinational next-state logic. The result for the byte on
// the inputs is presented combinationally; state advances when step is high.
// ----------------------------------------------------------------------------
module rwp_parse_core import rwp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	output logic        res_valid,
	output rwp_result_t res
);

	typedef enum logic [3:0] {
		PH_MAGIC, PH_RSIZE, PH_WAVE, PH_CHID, PH_CHSIZE, PH_SKIP,
		PH_FMT, PH_DATA, PH_PENDING, PH_DONE, PH_FAIL
	} phase_t;

	typedef enum logic [1:0] {
		SK_SKIP, SK_FMT, SK_DATA, SK_OTHER
	} sub_kind_t;

	phase_t      phase_q, phase_n;
	sub_kind_t   kind_q, kind_n;
	logic [3:0]  cnt_q, cnt_n;
	logic [31:0] outer_q, outer_n;
	logic [31:0] sublen_q, sublen_n;
	logic [31:0] shift_q, shift_n;
	logic [31:0] rate_q, rate_n;
	logic        data_seen_q, data_seen_n;

	logic        fail;
	err_code_t   fcode;
	logic        emit_sample;
	logic        emit_done;
	logic        do_bnd;

	always_comb begin
		phase_n     = phase_q;
		kind_n      = kind_q;
		cnt_n       = cnt_q;
		outer_n     = outer_q;
		sublen_n    = sublen_q;
		shift_n     = shift_q;
		rate_n      = rate_q;
		data_seen_n = data_seen_q;
		fail        = 1'b0;
		fcode       = ERR_NONE;
		emit_sample = 1'b0;
		emit_done   = 1'b0;
		do_bnd      = 1'b0;

		case (phase_q)
			PH_FAIL, PH_DONE: begin
			end
			PH_PENDING: begin
				do_bnd = 1'b1;
			end
			default: begin
				shift_n = {data_byte, shift_q[31:8]};
				cnt_n   = cnt_q + 4'd1;
				case (phase_q)
					PH_MAGIC: begin
						if (cnt_q == 4'd3) begin
							if (shift_n != TAG_RIFF) begin
								fail  = 1'b1;
								fcode = ERR_MAGIC;
							end else begin
								phase_n = PH_RSIZE;
								cnt_n   = '0;
							end
						end
					end
					PH_RSIZE: begin
						if (cnt_q == 4'd3) begin
							if (shift_n < WAVE_TAG_LEN) begin
								fail  = 1'b1;
								fcode = ERR_OVERRUN;
							end else begin
								outer_n = shift_n - WAVE_TAG_LEN;
								phase_n = PH_WAVE;
								cnt_n   = '0;
							end
						end
					end
					PH_WAVE: begin
						if (cnt_q == 4'd3) begin
							if (shift_n != TAG_WAVE) begin
								fail  = 1'b1;
								fcode = ERR_NOT_WAVE;
							end else begin
								do_bnd = 1'b1;
							end
						end
					end
					PH_CHID: begin
						if (cnt_q == 4'd3) begin
							if (shift_n == TAG_LIST || shift_n == TAG_ID3 ||
								shift_n == TAG_FACT || shift_n == TAG_PEAK) begin
								kind_n = SK_SKIP;
							end else if (shift_n == TAG_FMT) begin
								kind_n = SK_FMT;
							end else if (shift_n == TAG_DATA) begin
								kind_n = SK_DATA;
							end else begin
								kind_n = SK_OTHER;
							end
							phase_n = PH_CHSIZE;
							cnt_n   = '0;
						end
					end
					PH_CHSIZE: begin
						if (cnt_q == 4'd3) begin
							if (shift_n > outer_q) begin
								fail  = 1'b1;
								fcode = ERR_OVERRUN;
							end else begin
								outer_n = outer_q - shift_n;
								cnt_n   = '0;
								case (kind_q)
									SK_SKIP: begin
										sublen_n = shift_n;
										if (shift_n == '0) begin
											do_bnd = 1'b1;
										end else begin
											phase_n = PH_SKIP;
										end
									end
									SK_FMT: begin
										if (rate_q != '0) begin
											fail  = 1'b1;
											fcode = ERR_DUP_FMT;
										end else if (shift_n != FMT_CHUNK_LEN) begin
											fail  = 1'b1;
											fcode = ERR_FMT_SIZE;
										end else begin
											phase_n = PH_FMT;
										end
									end
									SK_DATA: begin
										if (data_seen_q) begin
											fail  = 1'b1;
											fcode = ERR_DUP_DATA;
										end else if (shift_n == '0) begin
											fail  = 1'b1;
											fcode = ERR_EMPTY_DATA;
										end else if (shift_n[1:0] != 2'd0) begin
											fail  = 1'b1;
											fcode = ERR_PARTIAL;
										end else begin
											data_seen_n = 1'b1;
											sublen_n    = shift_n;
											phase_n     = PH_DATA;
										end
									end
									default: begin
										fail  = 1'b1;
										fcode = ERR_UNKNOWN_ID;
									end
								endcase
							end
						end
					end
					PH_SKIP: begin
						sublen_n = sublen_q - 32'd1;
						if (sublen_q == 32'd1) begin
							do_bnd = 1'b1;
						end
					end
					PH_FMT: begin
						// cnt_q is the byte index within the 16-byte fmt body
						case (cnt_q)
							4'd1: begin
								if (shift_n[31:16] != FMT_IEEE_FLOAT) begin
									fail  = 1'b1;
									fcode = ERR_FORMAT;
								end
							end
							4'd3: begin
								if (shift_n[31:16] != FMT_MONO) begin
									fail  = 1'b1;
									fcode = ERR_CHANNELS;
								end
							end
							4'd7: begin
								if (shift_n == '0) begin
									fail  = 1'b1;
									fcode = ERR_RATE_ZERO;
								end else begin
									rate_n = shift_n;
								end
							end
							4'd11: begin
								if (shift_n != {rate_q[29:0], 2'b00}) begin
									fail  = 1'b1;
									fcode = ERR_BYTE_RATE;
								end
							end
							4'd13: begin
								if (shift_n[31:16] != FMT_BLOCK_ALIGN) begin
									fail  = 1'b1;
									fcode = ERR_ALIGN;
								end
							end
							4'd15: begin
								if (shift_n[31:16] != FMT_SAMPLE_BITS) begin
									fail  = 1'b1;
									fcode = ERR_BITS;
								end else begin
									do_bnd = 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
					PH_DATA: begin
						sublen_n = sublen_q - 32'd1;
						if (cnt_q == 4'd3) begin
							cnt_n       = '0;
							emit_sample = 1'b1;
							if (sublen_q == 32'd1) begin
								// hold the verdict one request when no further chunk header fits
								if (outer_q < CHUNK_HDR_LEN) begin
									phase_n = PH_PENDING;
								end else begin
									do_bnd = 1'b1;
								end
							end
						end
					end
					default: begin
						fail  = 1'b1;
						fcode = ERR_TRUNCATED;
					end
				endcase
			end
		endcase

		// Chunk boundary: finish or fail the file, or take the next header off the count
		if (do_bnd) begin
			if (outer_q == '0) begin
				if (rate_q == '0) begin
					fail  = 1'b1;
					fcode = ERR_NO_FMT;
				end else if (!data_seen_q) begin
					fail  = 1'b1;
					fcode = ERR_NO_DATA;
				end else begin
					phase_n   = PH_DONE;
					emit_done = 1'b1;
				end
			end else if (outer_q < CHUNK_HDR_LEN) begin
				fail  = 1'b1;
				fcode = ERR_OVERRUN;
			end else begin
				outer_n = outer_q - CHUNK_HDR_LEN;
				phase_n = PH_CHID;
				cnt_n   = '0;
			end
		end

		// Early end mark on a byte that leaves the file unfinished
		if (end_of_stream && !fail && phase_q != PH_PENDING && phase_q != PH_DONE &&
			phase_q != PH_FAIL && phase_n != PH_PENDING && phase_n != PH_DONE) begin
			fail  = 1'b1;
			fcode = ERR_TRUNCATED;
		end

		if (fail) begin
			phase_n = PH_FAIL;
		end
	end

	always_comb begin
		res       = '0;
		res_valid = fail || emit_done || emit_sample;
		if (fail) begin
			res.kind       = RK_ERROR;
			res.error_code = fcode;
		end else if (emit_done) begin
			res.kind    = RK_DONE;
			res.rate_hz = rate_q;
		end else begin
			res.kind        = RK_SAMPLE;
			res.sample_bits = emit_sample ? shift_n : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MAGIC;
			kind_q      <= SK_SKIP;
			cnt_q       <= '0;
			outer_q     <= '0;
			sublen_q    <= '0;
			shift_q     <= '0;
			rate_q      <= '0;
			data_seen_q <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_n;
			kind_q      <= kind_n;
			cnt_q       <= cnt_n;
			outer_q     <= outer_n;
			sublen_q    <= sublen_n;
			shift_q     <= shift_n;
			rate_q      <= rate_n;
			data_seen_q <= data_seen_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FAIL |=> phase_q == PH_FAIL)
		else $error("parse phase left the failed state");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("parse phase left the complete state");

	a_silent_when_finished: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE || phase_q == PH_FAIL) |-> !res_valid)
		else $error("result produced after the file finished");

	a_error_enters_fail: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && res.kind == RK_ERROR |=> phase_q == PH_FAIL)
		else $error("error result without entering the failed state");
`endif

endmodule

FILE: hw/rtl/riff_wav_float_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// riff_wav_float_stream_parser_unit
// Byte-serial RIFF/WAVE parser for mono 32-bit IEEE float audio.
// ----------------------------------------------------------------------------
// Usage:
//   bytes   : one file byte per request, with end_of_stream on the last byte
//             the source has.
//   results : a sample word (kind 0) for every four bytes of the data chunk,
//             then one completion (kind 1, rate_hz) or one error (kind 2,
//             error_code). Samples already given out are void if an error
//             follows. After completion or an error, further bytes are taken
//             and dropped until reset.
// Timing: a byte is registered at the input, parsed by the combinational
//   next-state logic of the parse state, and its result lands in the output
//   register, where it is held until taken. One byte is taken every cycle
//   while no result waits on a stalled output register; the limit is the
//   update of the parse state.
//   When the data chunk ends the file, the verdict takes one extra byte slot.
// Stall: a byte that yields no result keeps flowing while results is stalled;
//   a byte that yields a result waits in the input register until the output
//   register frees up, and bytes then backs up.
// Reset: arst_n clears the parser to expect the RIFF magic; no results pend.
// ----------------------------------------------------------------------------
module riff_wav_float_stream_parser_unit import rwp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	rwp_in_if.sink    bytes,
	rwp_out_if.source results
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eos_s1;

	logic        res_valid;
	rwp_result_t res;
	logic        advance;

	logic        out_valid_q;
	rwp_result_t out_res_q;

	assign advance     = valid_s1 && (!res_valid || !out_valid_q || results.ready);
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.data_byte;
			eos_s1  <= bytes.end_of_stream;
		end
	end

	rwp_parse_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.data_byte     (byte_s1),
		.end_of_stream (eos_s1),
		.res_valid     (res_valid),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_res_q <= res;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.kind        = out_res_q.kind;
	assign results.sample_bits = out_res_q.sample_bits;
	assign results.rate_hz     = out_res_q.rate_hz;
	assign results.error_code  = out_res_q.error_code;

`ifndef NO_ASSERTIONS
	a_hold_stalled_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(eos_s1))
		else $error("stalled byte lost from the input register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_valid |-> !out_valid_q || results.ready)
		else $error("result register overwritten while occupied");

	a_sample_clean: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.kind == RK_SAMPLE |->
			results.rate_hz == '0 && results.error_code == ERR_NONE)
		else $error("sample result carries rate or error bits");

	a_error_coded: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.kind == RK_ERROR |->
			results.error_code != ERR_NONE && results.sample_bits == '0)
		else $error("error result without an error code");
`endif

endmodule

FILE: bench/wav_check_pkg.sv
// ----------------------------------------------------------------------------
// wav_check_pkg
// Byte-level tracker for the RIFF/WAVE float parser bench: follows the file
// byte by byte, keeps the results the parser owes and checks each one that
// comes back against the oldest of them.
// ----------------------------------------------------------------------------
package wav_check_pkg;
	import rwp_pkg::*;

	typedef enum logic [3:0] {
		PH_MAGIC,
		PH_RSIZE,
		PH_WAVE,
		PH_CHID,
		PH_CHSIZE,
		PH_SKIP,
		PH_FMT,
		PH_DATA,
		PH_PENDING,
		PH_DONE,
		PH_FAIL
	} parse_phase_t;

	typedef enum logic [1:0] {
		CK_SKIP,
		CK_FMT,
		CK_DATA,
		CK_OTHER
	} chunk_kind_t;

	class wav_stream_tracker;
		parse_phase_t phase;
		chunk_kind_t  sub_kind;
		logic [31:0]  field_cnt;
		logic [31:0]  outer_left;
		logic [31:0]  sub_len;
		logic [31:0]  shift_word;
		logic [31:0]  rate;
		bit           data_seen;
		rwp_result_t  parser_outputs_due[$];
		int unsigned  mismatches;
		int unsigned  results_seen;
		int unsigned  samples_seen;

		function new();
			phase = PH_MAGIC;
			sub_kind = CK_SKIP;
			field_cnt = '0;
			outer_left = '0;
			sub_len = '0;
			shift_word = '0;
			rate = '0;
			data_seen = 1'b0;
			mismatches = 0;
			results_seen = 0;
			samples_seen = 0;
		endfunction

		function int unsigned due();
			return parser_outputs_due.size();
		endfunction

		function bit fail_with(err_code_t code, output rwp_result_t r);
			phase = PH_FAIL;
			r = '0;
			r.kind = RK_ERROR;
			r.error_code = code;
			return 1'b1;
		endfunction

		// Take the header of the next sub-chunk off the outer count, or close or fail the file
		function bit chunk_edge(output rwp_result_t r);
			r = '0;
			if (outer_left == 0) begin
				if (rate == 0)
					return fail_with(ERR_NO_FMT, r);
				if (!data_seen)
					return fail_with(ERR_NO_DATA, r);
				phase = PH_DONE;
				r.kind = RK_DONE;
				r.rate_hz = rate;
				return 1'b1;
			end
			if (outer_left < CHUNK_HDR_LEN)
				return fail_with(ERR_OVERRUN, r);
			outer_left -= CHUNK_HDR_LEN;
			phase = PH_CHID;
			field_cnt = '0;
			return 1'b0;
		endfunction

		function bit parse_byte(logic [7:0] b, bit eos, output rwp_result_t r);
			logic [31:0] idx;
			logic [31:0] len;
			rwp_result_t spare;
			bit got;
			r = '0;
			got = 1'b0;
			if (phase == PH_FAIL || phase == PH_DONE)
				return 1'b0;
			// the byte after a closing data chunk only carries the verdict
			if (phase == PH_PENDING)
				return chunk_edge(r);
			shift_word = {b, shift_word[31:8]};
			idx = field_cnt;
			field_cnt++;
			case (phase)
				PH_MAGIC: begin
					if (field_cnt == 4) begin
						if (shift_word != TAG_RIFF)
							return fail_with(ERR_MAGIC, r);
						phase = PH_RSIZE;
						field_cnt = '0;
					end
				end
				PH_RSIZE: begin
					if (field_cnt == 4) begin
						outer_left = shift_word;
						if (outer_left < WAVE_TAG_LEN)
							return fail_with(ERR_OVERRUN, r);
						outer_left -= WAVE_TAG_LEN;
						phase = PH_WAVE;
						field_cnt = '0;
					end
				end
				PH_WAVE: begin
					if (field_cnt == 4) begin
						if (shift_word != TAG_WAVE)
							return fail_with(ERR_NOT_WAVE, r);
						got = chunk_edge(r);
					end
				end
				PH_CHID: begin
					if (field_cnt == 4) begin
						if (shift_word == TAG_LIST || shift_word == TAG_ID3 ||
								shift_word == TAG_FACT || shift_word == TAG_PEAK)
							sub_kind = CK_SKIP;
						else if (shift_word == TAG_FMT)
							sub_kind = CK_FMT;
						else if (shift_word == TAG_DATA)
							sub_kind = CK_DATA;
						else
							sub_kind = CK_OTHER;
						phase = PH_CHSIZE;
						field_cnt = '0;
					end
				end
				PH_CHSIZE: begin
					if (field_cnt == 4) begin
						len = shift_word;
						if (len > outer_left)
							return fail_with(ERR_OVERRUN, r);
						outer_left -= len;
						field_cnt = '0;
						case (sub_kind)
							CK_SKIP: begin
								sub_len = len;
								if (len == 0)
									got = chunk_edge(r);
								else
									phase = PH_SKIP;
							end
							CK_FMT: begin
								if (rate != 0)
									return fail_with(ERR_DUP_FMT, r);
								if (len != FMT_CHUNK_LEN)
									return fail_with(ERR_FMT_SIZE, r);
								phase = PH_FMT;
							end
							CK_DATA: begin
								if (data_seen)
									return fail_with(ERR_DUP_DATA, r);
								if (len == 0)
									return fail_with(ERR_EMPTY_DATA, r);
								if (len[1:0] != 2'b00)
									return fail_with(ERR_PARTIAL, r);
								data_seen = 1'b1;
								sub_len = len;
								phase = PH_DATA;
							end
							default: begin
								return fail_with(ERR_UNKNOWN_ID, r);
							end
						endcase
					end
				end
				PH_SKIP: begin
					sub_len--;
					if (sub_len == 0)
						got = chunk_edge(r);
				end
				PH_FMT: begin
					case (idx)
						1: if (shift_word[31:16] != FMT_IEEE_FLOAT)
							return fail_with(ERR_FORMAT, r);
						3: if (shift_word[31:16] != FMT_MONO)
							return fail_with(ERR_CHANNELS, r);
						7: begin
							if (shift_word == 0)
								return fail_with(ERR_RATE_ZERO, r);
							rate = shift_word;
						end
						11: if (shift_word != (rate << 2))
							return fail_with(ERR_BYTE_RATE, r);
						13: if (shift_word[31:16] != FMT_BLOCK_ALIGN)
							return fail_with(ERR_ALIGN, r);
						15: begin
							if (shift_word[31:16] != FMT_SAMPLE_BITS)
								return fail_with(ERR_BITS, r);
							got = chunk_edge(r);
						end
						default: ;
					endcase
				end
				PH_DATA: begin
					sub_len--;
					if (field_cnt == 4) begin
						field_cnt = '0;
						r.kind = RK_SAMPLE;
						r.sample_bits = shift_word;
						got = 1'b1;
						if (sub_len == 0) begin
							// hold the verdict for one more byte when no further chunk header fits
							if (outer_left < CHUNK_HDR_LEN)
								phase = PH_PENDING;
							else
								void'(chunk_edge(spare));
						end
					end
				end
				default: begin
					return fail_with(ERR_TRUNCATED, r);
				end
			endcase
			if (eos && phase <= PH_DATA)
				return fail_with(ERR_TRUNCATED, r);
			return got;
		endfunction

		function void note_byte(logic [7:0] b, bit eos);
			rwp_result_t r;
			if (parse_byte(b, eos, r))
				parser_outputs_due.push_back(r);
		endfunction

		function void check_result(rwp_result_t seen);
			rwp_result_t want;
			results_seen++;
			if (seen.kind == RK_SAMPLE)
				samples_seen++;
			if (parser_outputs_due.size() == 0) begin
				$error("result of kind %0d arrived with nothing due", seen.kind);
				mismatches++;
				return;
			end
			want = parser_outputs_due.pop_front();
			if (seen.kind != want.kind) begin
				$error("kind: expected %0d, actual %0d", want.kind, seen.kind);
				mismatches++;
			end
			if (seen.sample_bits != want.sample_bits) begin
				$error("sample_bits: expected %08h, actual %08h",
					want.sample_bits, seen.sample_bits);
				mismatches++;
			end
			if (seen.rate_hz != want.rate_hz) begin
				$error("rate_hz: expected %0d, actual %0d", want.rate_hz, seen.rate_hz);
				mismatches++;
			end
			if (seen.error_code != want.error_code) begin
				$error("error_code: expected %0d, actual %0d",
					want.error_code, seen.error_code);
				mismatches++;
			end
		endfunction
	endclass

endpackage

FILE: bench/riff_wav_float_stream_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// riff_wav_float_stream_parser_unit_tb
// Streams one generated RIFF/WAVE file through the parser: a well-formed mono
// float file most of the time, otherwise one with a single defect in it.
// Both channels idle at random; every result is checked in order.
// ----------------------------------------------------------------------------
module riff_wav_float_stream_parser_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rwp_pkg::*;
	import wav_check_pkg::*;

	typedef enum int {
		F_NONE,
		F_MAGIC,
		F_WAVE,
		F_RSIZE_SMALL,
		F_OUTER_TAIL,
		F_CHUNK_OVERRUN,
		F_DUP_FMT,
		F_FMT_SIZE,
		F_FORMAT,
		F_CHANNELS,
		F_RATE_ZERO,
		F_BYTE_RATE,
		F_ALIGN,
		F_BITS,
		F_DUP_DATA,
		F_EMPTY_DATA,
		F_PARTIAL,
		F_UNKNOWN_ID,
		F_NO_FMT,
		F_NO_DATA,
		F_TRUNCATED
	} file_fault_t;

	logic clk = 1'b0;
	logic arst_n;

	rwp_in_if  bytes_if ();
	rwp_out_if results_if ();

	riff_wav_float_stream_parser_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes_if),
		.results (results_if)
	);

	wav_stream_tracker tracker;
	file_fault_t       fault;
	logic [7:0]        chunk_bytes[$];
	logic [7:0]        file_bytes[$];
	int                eos_at;
	int unsigned       sent;
	bit                tx_calm;
	bit                rx_calm;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned idle_span(bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [15:0] spoil16(logic [15:0] v);
		return v ^ 16'($urandom_range(1, 16'hFFFF));
	endfunction

	function automatic void put_word(logic [31:0] w);
		for (int i = 0; i < 4; i++)
			chunk_bytes.push_back(w[8*i +: 8]);
	endfunction

	function automatic void put_half(logic [15:0] h);
		chunk_bytes.push_back(h[7:0]);
		chunk_bytes.push_back(h[15:8]);
	endfunction

	function automatic void put_skip_chunk(int unsigned max_len);
		int unsigned len;
		case ($urandom_range(0, 3))
			0: put_word(TAG_LIST);
			1: put_word(TAG_ID3);
			2: put_word(TAG_FACT);
			default: put_word(TAG_PEAK);
		endcase
		len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, max_len);
		put_word(len);
		repeat (len) chunk_bytes.push_back(8'($urandom()));
	endfunction

	function automatic void put_fmt(logic [31:0] rate);
		logic [31:0] len;
		len = FMT_CHUNK_LEN;
		if (fault == F_FMT_SIZE)
			len = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 15)) :
				FMT_CHUNK_LEN ^ 32'($urandom_range(1, 32'hFFFF_FFFF));
		put_word(TAG_FMT);
		put_word(len);
		put_half(fault == F_FORMAT ? spoil16(FMT_IEEE_FLOAT) : FMT_IEEE_FLOAT);
		put_half(fault == F_CHANNELS ? spoil16(FMT_MONO) : FMT_MONO);
		put_word(fault == F_RATE_ZERO ? 32'd0 : rate);
		put_word(fault == F_BYTE_RATE ?
			(rate << 2) ^ 32'($urandom_range(1, 32'hFFFF_FFFF)) : rate << 2);
		put_half(fault == F_ALIGN ? spoil16(FMT_BLOCK_ALIGN) : FMT_BLOCK_ALIGN);
		put_half(fault == F_BITS ? spoil16(FMT_SAMPLE_BITS) : FMT_SAMPLE_BITS);
	endfunction

	function automatic void put_data(int unsigned nsamp);
		logic [31:0] len;
		logic [31:0] word;
		len = 4 * nsamp;
		if (fault == F_EMPTY_DATA)
			len = 0;
		else if (fault == F_PARTIAL)
			len = len + $urandom_range(1, 3);
		put_word(TAG_DATA);
		put_word(len);
		for (int i = 0; i < nsamp; i++) begin
			case (i)
				0: word = 32'h0000_0000;
				1: word = 32'hFFFF_FFFF;
				2: word = 32'h7F80_0000;
				3: word = 32'h8000_0000;
				default: word = $urandom();
			endcase
			put_word(word);
		end
	endfunction

	task automatic build_file();
		logic [7:0]  body[$];
		logic [31:0] rate;
		logic [31:0] riff_size;
		logic [31:0] tag;
		int unsigned nsamp;
		int unsigned extra;
		bit          fmt_first;
		fault = ($urandom_range(0, 99) < 65) ? F_NONE :
			file_fault_t'($urandom_range(F_MAGIC, F_TRUNCATED));
		nsamp = $urandom_range(320, 345);
		case ($urandom_range(0, 4))
			0: rate = 32'd1;
			1: rate = 32'hFFFF_FFFF;
			2: rate = 32'd44100;
			3: rate = 32'd48000;
			default: rate = $urandom_range(1, 200000);
		endcase
		// keep fmt defects behind the samples so that the data path is exercised first
		fmt_first = (fault inside {F_FMT_SIZE, F_FORMAT, F_CHANNELS, F_RATE_ZERO,
			F_BYTE_RATE, F_ALIGN, F_BITS}) ? 1'b0 : 1'($urandom_range(0, 1));
		chunk_bytes = {};
		repeat ($urandom_range(0, 2)) put_skip_chunk(24);
		if (fault == F_NO_DATA)
			repeat (6) put_skip_chunk(200);
		if (fmt_first && fault != F_NO_FMT)
			put_fmt(rate);
		if (fault != F_NO_DATA)
			put_data(nsamp);
		repeat ($urandom_range(0, 1)) put_skip_chunk(24);
		if (!fmt_first && fault != F_NO_FMT)
			put_fmt(rate);
		case (fault)
			F_DUP_FMT: put_fmt(rate);
			F_DUP_DATA: put_data($urandom_range(1, 4));
			F_UNKNOWN_ID: begin
				do
					tag = $urandom();
				while (tag inside {TAG_LIST, TAG_ID3, TAG_FACT, TAG_PEAK, TAG_FMT, TAG_DATA});
				extra = $urandom_range(0, 8);
				put_word(tag);
				put_word(extra);
				repeat (extra) chunk_bytes.push_back(8'($urandom()));
			end
			F_CHUNK_OVERRUN: begin
				put_word(TAG_LIST);
				put_word(($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF :
					32'($urandom_range(5, 40)));
				put_word($urandom());
			end
			F_OUTER_TAIL: begin
				repeat ($urandom_range(1, 7)) chunk_bytes.push_back(8'($urandom()));
			end
			default: ;
		endcase
		body = chunk_bytes;
		riff_size = WAVE_TAG_LEN + body.size();
		if (fault == F_RSIZE_SMALL)
			riff_size = $urandom_range(0, 3);
		chunk_bytes = {};
		put_word(fault == F_MAGIC ? TAG_RIFF ^ (32'h1 << $urandom_range(0, 31)) : TAG_RIFF);
		put_word(riff_size);
		put_word(fault == F_WAVE ? TAG_WAVE ^ (32'h1 << $urandom_range(0, 31)) : TAG_WAVE);
		file_bytes = {chunk_bytes, body};
		eos_at = -1;
		if (fault == F_TRUNCATED)
			eos_at = $urandom_range(file_bytes.size() / 2, file_bytes.size() - 2);
		else if ($urandom_range(0, 1) == 1)
			eos_at = file_bytes.size() - 1;
		// bytes past the end of the file: the first one carries a held verdict if there is one
		repeat ($urandom_range(2, 6)) file_bytes.push_back(8'($urandom()));
	endtask

	task automatic send_byte(input logic [7:0] b, input logic eos);
		int unsigned gap;
		gap = idle_span(tx_calm);
		if (gap != 0) begin
			bytes_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bytes_if.valid <= 1'b1;
		bytes_if.data_byte <= b;
		bytes_if.end_of_stream <= eos;
		do
			@(posedge clk);
		while (!bytes_if.ready);
		tracker.note_byte(b, eos);
		sent++;
	endtask

	// Result side: random back-pressure with calm stretches
	initial begin
		int unsigned stall_left;
		int unsigned cycle;
		stall_left = 0;
		cycle = 0;
		results_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle % 256 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			if (stall_left != 0) begin
				stall_left--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= 1'b1;
				stall_left = idle_span(rx_calm);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready)
			tracker.check_result({results_if.kind, results_if.sample_bits,
				results_if.rate_hz, results_if.error_code});
	end

	initial begin
		int unsigned pause_at;
		arst_n = 1'b0;
		bytes_if.valid = 1'b0;
		bytes_if.data_byte = 8'h00;
		bytes_if.end_of_stream = 1'b0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		sent = 0;
		tracker = new();
		build_file();
		pause_at = $urandom_range(16, file_bytes.size() - 1);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (file_bytes[i]) begin
			if (i % 128 == 0)
				tx_calm = ($urandom_range(0, 3) == 0);
			// hold the byte stream until the parser has caught up
			if (i == pause_at) begin
				bytes_if.valid <= 1'b0;
				do
					@(posedge clk);
				while (tracker.due() != 0);
			end
			send_byte(file_bytes[i], (i == eos_at) || (i == file_bytes.size() - 1));
		end
		bytes_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.due() != 0);
		repeat (16) @(posedge clk);
		$display("Sent %0d bytes of a %s file; %0d results checked, %0d of them samples",
			sent, fault.name(), tracker.results_seen, tracker.samples_seen);
		if (tracker.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/rwp_pkg.sv
hw/rtl/rwp_in_if.sv
hw/rtl/rwp_out_if.sv
hw/rtl/rwp_parse_core.sv
hw/rtl/riff_wav_float_stream_parser_unit.sv
bench/wav_check_pkg.sv
bench/riff_wav_float_stream_parser_unit_tb.sv
